[src/aesctr_pkg.sv]
package aesctr_pkg;

  // Bytes in one keystream block.
  localparam int unsigned BLOCK_BYTES = 16;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
  localparam logic [2:0] REG_KEY_W0     = 3'd1;
  localparam logic [2:0] REG_KEY_W1     = 3'd2;
  localparam logic [2:0] REG_KEY_W2     = 3'd3;
  localparam logic [2:0] REG_KEY_W3     = 3'd4;
  localparam logic [2:0] REG_IV_HIGH    = 3'd5;
  localparam logic [2:0] REG_IV_LOW     = 3'd6;

  // Key length codes.
  localparam logic [1:0] KEY_128 = 2'd0;
  localparam logic [1:0] KEY_192 = 2'd1;

  // Key length in words (Nk).
  localparam logic [3:0] NK_128 = 4'd4;
  localparam logic [3:0] NK_192 = 4'd6;
  localparam logic [3:0] NK_256 = 4'd8;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Eight-word key schedule window: word 7 is the newest.
  typedef logic [7:0][31:0] win_t;

  // Key schedule position: window, word index modulo Nk and round constant.
  typedef struct packed {
    win_t       win;
    logic [2:0] m;
    logic [7:0] rc;
  } ksched_t;

  // Control from the top level to the keystream front end.
  typedef struct packed {
    logic         abort;
    logic         load;
    logic [127:0] value;
  } front_ctl_t;

  // One finished keystream block with the counter it was made from.
  typedef struct packed {
    logic         valid;
    logic [127:0] ks;
    logic [127:0] ctr;
  } ks_blk_t;

  // Configuration events seen by the back end.
  typedef struct packed {
    logic key_wr;
    logic iv_wr;
  } flush_t;

  // Counter restart requested by the back end after a key change.
  typedef struct packed {
    logic         load;
    logic [127:0] value;
  } restart_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Generate one key schedule word and slide the window by one.
  function automatic ksched_t kstep(input ksched_t a, input logic [3:0] nk);
    ksched_t     r;
    logic [31:0] tmp;
    logic [31:0] old;
    logic [7:0]  rc;
    r   = a;
    tmp = a.win[7];
    rc  = a.rc;
    if (a.m == 3'd0) begin
      tmp = sub_word({tmp[23:0], tmp[31:24]}) ^ {rc, 24'h0};
      rc  = xt(rc);
    end else if (nk == NK_256 && a.m == 3'd4) begin
      tmp = sub_word(tmp);
    end
    case (nk)
      NK_128:  old = a.win[4];
      NK_192:  old = a.win[2];
      default: old = a.win[0];
    endcase
    r.win = {old ^ tmp, a.win[7:1]};
    r.rc  = rc;
    r.m   = ({1'b0, a.m} + 4'd1 == nk) ? 3'd0 : a.m + 3'd1;
    kstep = r;
  endfunction

  // SubBytes, ShiftRows and, except in the last round, MixColumns.
  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic last);
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[c*4+j] = SBOX[s[127 - 8*((((c + j) & 3) * 4) + j) -: 8]];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4];
        a1 = t[c*4+1];
        a2 = t[c*4+2];
        a3 = t[c*4+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[c*4]   = a0 ^ all ^ xt(a0 ^ a1);
        t[c*4+1] = a1 ^ all ^ xt(a1 ^ a2);
        t[c*4+2] = a2 ^ all ^ xt(a2 ^ a3);
        t[c*4+3] = a3 ^ all ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127 - 8*i -: 8] = t[i];
    end
    round_fn = r;
  endfunction

endpackage

[src/aesctr_core.sv]
module aesctr_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         abort,
  input  logic [1:0]   key_length,
  input  logic [255:0] key,
  input  logic [127:0] blk_in,
  output logic         idle,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [127:0] out_blk
);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_PRE  = 4'b0010,
    C_RUN  = 4'b0100,
    C_DONE = 4'b1000
  } core_st_t;

  core_st_t             st;
  logic [127:0]         s;
  logic [3:0]           rnd;
  logic [3:0]           nk;
  aesctr_pkg::ksched_t  ks;
  aesctr_pkg::ksched_t  k1, k2, k3, k4;
  aesctr_pkg::ksched_t  ks_load;
  logic [3:0]           nk_next;
  logic [3:0]           nr;
  logic [127:0]         rk;

  // Key length decode; the unused code runs as a 256-bit key.
  always_comb begin
    case (key_length)
      aesctr_pkg::KEY_128: nk_next = aesctr_pkg::NK_128;
      aesctr_pkg::KEY_192: nk_next = aesctr_pkg::NK_192;
      default:             nk_next = aesctr_pkg::NK_256;
    endcase
  end

  // Initial window holds the key words at the newest end.
  always_comb begin
    ks_load.win = '0;
    ks_load.m   = 3'd0;
    ks_load.rc  = 8'h01;
    for (int j = 0; j < 8; j++) begin
      if (j < 4 || nk_next == aesctr_pkg::NK_256 ||
          (nk_next == aesctr_pkg::NK_192 && j < 6)) begin
        ks_load.win[j + 8 - int'(nk_next)] = key[255 - 32*j -: 32];
      end
    end
  end

  // Four chained key schedule steps give the next round key.
  always_comb begin
    k1 = aesctr_pkg::kstep(ks, nk);
    k2 = aesctr_pkg::kstep(k1, nk);
    k3 = aesctr_pkg::kstep(k2, nk);
    k4 = aesctr_pkg::kstep(k3, nk);
  end

  assign nr        = nk + 4'd6;
  assign rk        = {ks.win[0], ks.win[1], ks.win[2], ks.win[3]};
  assign idle      = (st == C_IDLE);
  assign out_valid = (st == C_DONE);
  assign out_blk   = s;

  // Round sequencer: one round per cycle.
  always_ff @(posedge clk) begin
    if (rst || abort) begin
      st <= C_IDLE;
    end else begin
      case (st)
        C_IDLE: begin
          if (start) begin
            st <= (nk_next == aesctr_pkg::NK_256) ? C_RUN : C_PRE;
          end
        end
        C_PRE:  st <= C_RUN;
        C_RUN: begin
          if (rnd == nr) begin
            st <= C_DONE;
          end
        end
        C_DONE: begin
          if (out_ready) begin
            st <= C_IDLE;
          end
        end
        default: st <= C_IDLE;
      endcase
    end
  end

  // Data path: state, round count and key schedule window.
  always_ff @(posedge clk) begin
    case (st)
      C_IDLE: begin
        s   <= blk_in;
        nk  <= nk_next;
        ks  <= ks_load;
        rnd <= 4'd0;
      end
      C_PRE: begin
        ks <= (nk == aesctr_pkg::NK_128) ? k4 : k2;
      end
      C_RUN: begin
        s   <= ((rnd == 4'd0) ? s : aesctr_pkg::round_fn(s, rnd == nr)) ^ rk;
        ks  <= k4;
        rnd <= rnd + 4'd1;
      end
      default: begin
        s <= s;
      end
    endcase
  end

endmodule

[src/aesctr_front.sv]
module aesctr_front (
  input  logic                   clk,
  input  logic                   rst,
  input  aesctr_pkg::front_ctl_t ctl,
  input  logic [1:0]             key_length,
  input  logic [255:0]           key,
  output aesctr_pkg::ks_blk_t    push,
  input  logic                   push_ready
);

  logic [127:0] gen_ctr;
  logic         core_idle;
  logic         core_valid;
  logic [127:0] core_blk;
  logic         take;

  assign take = core_valid && push_ready && !ctl.abort;

  aesctr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .start      (core_idle && !ctl.abort),
    .abort      (ctl.abort),
    .key_length (key_length),
    .key        (key),
    .blk_in     (gen_ctr),
    .idle       (core_idle),
    .out_valid  (core_valid),
    .out_ready  (take),
    .out_blk    (core_blk)
  );

  assign push.valid = core_valid && !ctl.abort;
  assign push.ks    = core_blk;
  assign push.ctr   = gen_ctr;

  // Counter of the next block to encrypt.
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_ctr <= '0;
    end else if (ctl.load) begin
      gen_ctr <= ctl.value;
    end else if (take) begin
      gen_ctr <= gen_ctr + 128'd1;
    end
  end

endmodule

[src/aesctr_back.sv]
module aesctr_back (
  input  logic                clk,
  input  logic                rst,
  input  aesctr_pkg::ks_blk_t push,
  output logic                push_ready,
  input  aesctr_pkg::flush_t  flush,
  output aesctr_pkg::restart_t restart,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_data
);

  logic [127:0] q_ks  [2];
  logic [127:0] q_ctr [2];
  logic         hd;
  logic [1:0]   cnt;
  logic [3:0]   bp;
  logic         in_acc;
  logic         pop;
  logic         do_push;
  logic         tl;
  logic [7:0]   ks_byte;

  assign tl         = hd ^ cnt[0];
  assign push_ready = (cnt != 2'd2);
  assign in_ready   = (cnt != 2'd0) && (!out_valid || out_ready);
  assign in_acc     = in_valid && in_ready;
  assign pop        = in_acc && (bp == 4'(aesctr_pkg::BLOCK_BYTES - 1));
  assign do_push    = push.valid && push_ready;
  assign ks_byte    = q_ks[hd][127 - 8*bp -: 8];

  // After a key change only a partly used block is kept.
  assign restart.load  = (cnt != 2'd0);
  assign restart.value = q_ctr[hd] + ((bp != 4'd0) ? 128'd1 : 128'd0);

  // Block queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_ks[tl]  <= push.ks;
      q_ctr[tl] <= push.ctr;
    end
  end

  // Queue pointers and byte position in the head block.
  always_ff @(posedge clk) begin
    if (rst || flush.iv_wr) begin
      hd  <= 1'b0;
      cnt <= 2'd0;
      bp  <= 4'd0;
    end else if (flush.key_wr) begin
      if (cnt != 2'd0 && bp != 4'd0) begin
        cnt <= 2'd1;
      end else begin
        cnt <= 2'd0;
        bp  <= 4'd0;
      end
    end else begin
      cnt <= cnt + {1'b0, do_push} - {1'b0, pop};
      if (pop) begin
        hd <= ~hd;
      end
      if (in_acc) begin
        bp <= bp + 4'd1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data <= in_data ^ ks_byte;
    end
  end

endmodule

[src/aes_counter_mode_stream_cipher.sv]
// AES counter mode stream cipher: each input item carries one byte and yields one output byte,
// the input XORed with the next keystream byte; encryption and decryption are the same. An
// iterative AES unit runs one round per cycle and prefetches up to two 16-byte keystream blocks
// into a queue, so the stream runs at one byte per cycle for 128- and 192-bit keys while the
// output is not stalled, and slower for 256-bit keys. Writing iv_high or iv_low reloads the
// counter and discards all keystream, so the first byte after it waits for a new block. A key
// write keeps the block in use and regenerates the rest with the new key. Write configuration
// only while idle.
module aes_counter_mode_stream_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_in[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // data_out[7:0]
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [1:0]              key_length;
  logic [63:0]             key_w0, key_w1, key_w2, key_w3;
  logic [63:0]             iv_high, iv_low;
  logic                    key_wr;
  logic                    iv_wr;
  aesctr_pkg::front_ctl_t  ctl;
  aesctr_pkg::ks_blk_t     push;
  logic                    push_ready;
  aesctr_pkg::flush_t      flush;
  aesctr_pkg::restart_t    restart;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= '0;
      key_w0     <= '0;
      key_w1     <= '0;
      key_w2     <= '0;
      key_w3     <= '0;
      iv_high    <= '0;
      iv_low     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        aesctr_pkg::REG_KEY_LENGTH: key_length <= cfg_data[1:0];
        aesctr_pkg::REG_KEY_W0:     key_w0     <= cfg_data;
        aesctr_pkg::REG_KEY_W1:     key_w1     <= cfg_data;
        aesctr_pkg::REG_KEY_W2:     key_w2     <= cfg_data;
        aesctr_pkg::REG_KEY_W3:     key_w3     <= cfg_data;
        aesctr_pkg::REG_IV_HIGH:    iv_high    <= cfg_data;
        aesctr_pkg::REG_IV_LOW:     iv_low     <= cfg_data;
        default:                    key_length <= key_length;
      endcase
    end
  end

  // Write decode and counter reload.
  always_comb begin
    key_wr = cfg_wr_en && (cfg_index == aesctr_pkg::REG_KEY_LENGTH ||
                           cfg_index == aesctr_pkg::REG_KEY_W0 ||
                           cfg_index == aesctr_pkg::REG_KEY_W1 ||
                           cfg_index == aesctr_pkg::REG_KEY_W2 ||
                           cfg_index == aesctr_pkg::REG_KEY_W3);
    iv_wr  = cfg_wr_en && (cfg_index == aesctr_pkg::REG_IV_HIGH ||
                           cfg_index == aesctr_pkg::REG_IV_LOW);
    flush.key_wr = key_wr;
    flush.iv_wr  = iv_wr;
    ctl.abort = key_wr || iv_wr;
    ctl.load  = iv_wr || (key_wr && restart.load);
    if (iv_wr) begin
      ctl.value = (cfg_index == aesctr_pkg::REG_IV_HIGH) ? {cfg_data, iv_low}
                                                         : {iv_high, cfg_data};
    end else begin
      ctl.value = restart.value;
    end
  end

  aesctr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .key_length (key_length),
    .key        ({key_w0, key_w1, key_w2, key_w3}),
    .push       (push),
    .push_ready (push_ready)
  );

  aesctr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .flush      (flush),
    .restart    (restart),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata)
  );

  // An accepted item always leaves a result in the output register.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  // A result appears only after an accepted item.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("result without an accepted item");

  // An IV write discards all keystream, so no item is taken in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    iv_wr |=> !s_axis_tready)
    else $error("keystream survived an IV write");

endmodule
